// ----- sv/pagerank_iteration_engine_defines.svh -----
// Assertion macros for the engine's self-checks.
`ifndef PAGERANK_ITERATION_ENGINE_DEFINES_SVH
`define PAGERANK_ITERATION_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PIE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pie assertion failed");
// Next-cycle implication.
`define PIE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pie assertion failed");
`else
`define PIE_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PIE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/pie_pkg.sv -----
`timescale 1ns / 1ps
package pie_pkg;

	// Store sizes.
	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int EDGE_CW   = $clog2(MAX_EDGES + 1);
	localparam int DEG_W     = EDGE_CW;

	// Rank arithmetic.
	localparam int RANK_W  = 32;
	localparam int ACC_W   = RANK_W + EDGE_AW;
	localparam int HALF_W  = (ACC_W + 1) / 2;
	localparam int COEF_W  = 17;
	localparam int FRAC_W  = 16;
	localparam logic [RANK_W-1:0] ONE_Q16 = 32'h0001_0000;

	// Request kinds.
	localparam logic [1:0] KIND_EDGE    = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_DROPPED = 2'd1;
	localparam logic [1:0] STAT_DONE    = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_ITER    = 2'd0;
	localparam logic [1:0] REG_BASE    = 2'd1;
	localparam logic [1:0] REG_DAMPING = 2'd2;

	typedef struct packed {
		logic             present;
		logic [DEG_W-1:0] degree;
	} node_entry_t;

	typedef struct packed {
		logic [NODE_AW-1:0] src;
		logic [NODE_AW-1:0] dst;
	} edge_entry_t;

	typedef struct packed {
		logic              start;
		logic [RANK_W-1:0] dividend;
		logic [DEG_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [RANK_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- sv/pie_ram.sv -----
`timescale 1ns / 1ps
module pie_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/pie_div.sv -----
`timescale 1ns / 1ps
module pie_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pie_pkg::div_req_t req,
	output pie_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(pie_pkg::RANK_W);

	logic [pie_pkg::RANK_W-1:0] quo_q;
	logic [pie_pkg::DEG_W-1:0]  rem_q;
	logic [pie_pkg::DEG_W-1:0]  div_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pie_pkg::DEG_W:0]    trial;
	logic                       fits;

	// One restoring step per cycle: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, quo_q[pie_pkg::RANK_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pie_pkg::RANK_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath for the quotient and the partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pie_pkg::RANK_W-2:0], fits};
			rem_q <= fits ? pie_pkg::DEG_W'(trial - {1'b0, div_q})
			              : trial[pie_pkg::DEG_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- sv/pie_scale.sv -----
`timescale 1ns / 1ps
module pie_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [pie_pkg::ACC_W-1:0]   sum,
	input  logic [pie_pkg::COEF_W-1:0]  damping,
	input  logic [pie_pkg::COEF_W-1:0]  base,
	output logic                        out_valid,
	output logic [pie_pkg::RANK_W-1:0]  rank
);

	localparam int PROD_W = pie_pkg::HALF_W + pie_pkg::COEF_W;
	localparam int FULL_W = pie_pkg::ACC_W + pie_pkg::COEF_W;
	localparam int SHR_W  = FULL_W - pie_pkg::FRAC_W;

	logic [PROD_W-1:0]          plo_s1;
	logic [PROD_W-1:0]          phi_s1;
	logic                       valid_s1;
	logic                       valid_s2;
	logic [pie_pkg::RANK_W-1:0] rank_s2;
	logic [pie_pkg::HALF_W-1:0] sum_lo;
	logic [pie_pkg::HALF_W-1:0] sum_hi;
	logic [FULL_W-1:0]          full;
	logic [SHR_W:0]             biased;

	assign sum_lo = sum[pie_pkg::HALF_W-1:0];
	assign sum_hi = pie_pkg::HALF_W'(sum >> pie_pkg::HALF_W);

	// Recombine the partial products, drop the fraction, add the base and saturate.
	assign full   = (FULL_W'(phi_s1) << pie_pkg::HALF_W) + FULL_W'(plo_s1);
	assign biased = (SHR_W + 1)'(full >> pie_pkg::FRAC_W) + (SHR_W + 1)'(base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Two half-width products in the first stage, the sum in the second.
	always_ff @(posedge clk) begin
		plo_s1 <= PROD_W'(sum_lo) * PROD_W'(damping);
		phi_s1 <= PROD_W'(sum_hi) * PROD_W'(damping);
		if (biased > (SHR_W + 1)'({pie_pkg::RANK_W{1'b1}})) begin
			rank_s2 <= '1;
		end else begin
			rank_s2 <= biased[pie_pkg::RANK_W-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign rank      = rank_s2;

endmodule

// ----- sv/pagerank_iteration_engine.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  kind, src_node, dst_node
// rsp       out        rsp_valid/rsp_ready  node_index, rank_value, node_present, status
// apb       in         psel/penable/pready  pwrite, paddr, pwdata, prdata
// After reset a clearing pass writes all 1024 node entries before req_ready rises.
// An edge is a read-modify-write of source, then destination, on the node memory; a read
// fetches node and rank entries. A compute sets all ranks to ONE_Q16, then per sweep divides
// each edge's source rank by its degree in the serial divider and walks the nodes to scale.
// One transaction is in work at a time; its result waits in the result register while
// the next request is taken, and a stalled rsp holds the block only when that next result is due.
`include "pagerank_iteration_engine_defines.svh"
module pagerank_iteration_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  kind,
	input  logic [9:0]  src_node,
	input  logic [9:0]  dst_node,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [9:0]  node_index,
	output logic [31:0] rank_value,
	output logic        node_present,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NAW = pie_pkg::NODE_AW;
	localparam int EAW = pie_pkg::EDGE_AW;
	localparam int ECW = pie_pkg::EDGE_CW;
	localparam int RW  = pie_pkg::RANK_W;
	localparam int AW  = pie_pkg::ACC_W;
	localparam int CW  = pie_pkg::COEF_W;
	localparam int NW  = $bits(pie_pkg::node_entry_t);
	localparam int EW  = $bits(pie_pkg::edge_entry_t);

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_E_SRC  = 4'd2;
	localparam logic [3:0] ST_E_DST  = 4'd3;
	localparam logic [3:0] ST_READ   = 4'd4;
	localparam logic [3:0] ST_INIT   = 4'd5;
	localparam logic [3:0] ST_A_EDGE = 4'd6;
	localparam logic [3:0] ST_A_NODE = 4'd7;
	localparam logic [3:0] ST_A_DIV  = 4'd8;
	localparam logic [3:0] ST_A_WAIT = 4'd9;
	localparam logic [3:0] ST_A_ACC  = 4'd10;
	localparam logic [3:0] ST_B_READ = 4'd11;
	localparam logic [3:0] ST_B_SCL  = 4'd12;
	localparam logic [3:0] ST_B_WAIT = 4'd13;
	localparam logic [3:0] ST_RESULT = 4'd14;

	localparam logic [NAW-1:0] LAST_NODE = NAW'(pie_pkg::MAX_NODES - 1);

	logic [3:0]     state_q;
	logic [7:0]     iter_cfg_q;
	logic [CW-1:0]  base_cfg_q;
	logic [CW-1:0]  damp_cfg_q;
	logic [9:0]     src_q;
	logic [9:0]     dst_q;
	logic [ECW-1:0] edge_total_q;
	logic [ECW-1:0] ecnt_q;
	logic [NAW-1:0] cnt_q;
	logic [7:0]     it_q;
	logic [pie_pkg::DEG_W-1:0] deg_new_q;
	logic [NAW-1:0] edst_q;
	logic [RW-1:0]  quot_q;
	logic [9:0]     res_index_q;
	logic [RW-1:0]  res_rank_q;
	logic           res_present_q;
	logic [1:0]     res_status_q;
	logic           rsp_valid_q;
	logic [9:0]     rsp_index_q;
	logic [RW-1:0]  rsp_rank_q;
	logic           rsp_present_q;
	logic [1:0]     rsp_status_q;

	logic           node_we, node_re;
	logic [NAW-1:0] node_waddr, node_raddr;
	pie_pkg::node_entry_t node_wdata, node_rdata;
	logic           edge_we, edge_re;
	pie_pkg::edge_entry_t edge_wdata, edge_rdata;
	logic           rank_we, rank_re;
	logic [NAW-1:0] rank_waddr, rank_raddr;
	logic [RW-1:0]  rank_wdata, rank_rdata;
	logic           acc_we, acc_re;
	logic [NAW-1:0] acc_waddr, acc_raddr;
	logic [AW-1:0]  acc_wdata, acc_rdata;

	pie_pkg::div_req_t div_req;
	pie_pkg::div_rsp_t div_rsp;
	logic           div_start;
	logic           div_busy;
	logic           scale_in_valid;
	logic           scale_out_valid;
	logic [RW-1:0]  scale_rank;

	logic           edge_full;
	logic           cfg_write;
	logic           rsp_free;

	assign edge_full = edge_total_q == ECW'(pie_pkg::MAX_EDGES);
	assign cfg_write = psel && penable && pwrite && pready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = state_q == ST_IDLE;
	assign div_start = div_req.start;
	assign div_busy  = div_rsp.busy;

	// Memories: edge store, node flags and degrees, ranks, and sweep accumulators.
	pie_ram #(.DEPTH(pie_pkg::MAX_EDGES), .WIDTH(EW)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_total_q[EAW-1:0]), .wdata(edge_wdata),
		.re(edge_re), .raddr(ecnt_q[EAW-1:0]), .rdata(edge_rdata)
	);
	pie_ram #(.DEPTH(pie_pkg::MAX_NODES), .WIDTH(NW)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(node_rdata)
	);
	pie_ram #(.DEPTH(pie_pkg::MAX_NODES), .WIDTH(RW)) u_rank_ram (
		.clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
		.re(rank_re), .raddr(rank_raddr), .rdata(rank_rdata)
	);
	pie_ram #(.DEPTH(pie_pkg::MAX_NODES), .WIDTH(AW)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
	);

	pie_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	pie_scale u_scale (
		.clk(clk), .arst_n(arst_n), .in_valid(scale_in_valid), .sum(acc_rdata),
		.damping(damp_cfg_q), .base(base_cfg_q), .out_valid(scale_out_valid),
		.rank(scale_rank)
	);

	// Memory port control for each state.
	always_comb begin
		node_we          = 1'b0;
		node_re          = 1'b0;
		node_waddr       = cnt_q;
		node_raddr       = src_q;
		node_wdata       = '0;
		edge_we          = 1'b0;
		edge_re          = 1'b0;
		edge_wdata.src   = src_node;
		edge_wdata.dst   = dst_node;
		rank_we          = 1'b0;
		rank_re          = 1'b0;
		rank_waddr       = cnt_q;
		rank_raddr       = src_q;
		rank_wdata       = pie_pkg::ONE_Q16;
		acc_we           = 1'b0;
		acc_re           = 1'b0;
		acc_waddr        = cnt_q;
		acc_raddr        = cnt_q;
		acc_wdata        = '0;
		div_req.start    = 1'b0;
		div_req.dividend = rank_rdata;
		div_req.divisor  = node_rdata.degree;
		scale_in_valid   = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				node_we = 1'b1;
			end
			ST_IDLE: begin
				node_raddr = src_node;
				rank_raddr = src_node;
				if (req_valid) begin
					if (kind == pie_pkg::KIND_EDGE) begin
						edge_we = !edge_full;
						node_re = !edge_full;
					end else if (kind == pie_pkg::KIND_READ) begin
						node_re = 1'b1;
						rank_re = 1'b1;
					end
				end
			end
			ST_E_SRC: begin
				node_we            = 1'b1;
				node_waddr         = src_q;
				node_wdata.present = 1'b1;
				node_wdata.degree  = node_rdata.degree + 1'b1;
				node_re            = 1'b1;
				node_raddr         = dst_q;
			end
			ST_E_DST: begin
				// The read of the destination missed the source update when both match.
				node_we            = 1'b1;
				node_waddr         = dst_q;
				node_wdata.present = 1'b1;
				node_wdata.degree  = (dst_q == src_q) ? deg_new_q : node_rdata.degree;
			end
			ST_READ: begin
			end
			ST_INIT: begin
				rank_we = 1'b1;
				acc_we  = 1'b1;
			end
			ST_A_EDGE: begin
				edge_re = ecnt_q != edge_total_q;
			end
			ST_A_NODE: begin
				node_re    = 1'b1;
				node_raddr = edge_rdata.src;
				rank_re    = 1'b1;
				rank_raddr = edge_rdata.src;
			end
			ST_A_DIV: begin
				div_req.start = 1'b1;
			end
			ST_A_WAIT: begin
				acc_re    = div_rsp.done;
				acc_raddr = edst_q;
			end
			ST_A_ACC: begin
				acc_we    = 1'b1;
				acc_waddr = edst_q;
				acc_wdata = acc_rdata + AW'(quot_q);
			end
			ST_B_READ: begin
				acc_re = 1'b1;
			end
			ST_B_SCL: begin
				scale_in_valid = 1'b1;
			end
			ST_B_WAIT: begin
				rank_we    = scale_out_valid;
				rank_wdata = scale_rank;
				acc_we     = scale_out_valid;
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer for edges, reads and compute sweeps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			cnt_q        <= '0;
			ecnt_q       <= '0;
			it_q         <= '0;
			edge_total_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						if (kind == pie_pkg::KIND_EDGE) begin
							if (edge_full) begin
								state_q <= ST_RESULT;
							end else begin
								edge_total_q <= edge_total_q + 1'b1;
								state_q      <= ST_E_SRC;
							end
						end else if (kind == pie_pkg::KIND_COMPUTE) begin
							cnt_q   <= '0;
							state_q <= ST_INIT;
						end else if (kind == pie_pkg::KIND_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_E_SRC: state_q <= ST_E_DST;
				ST_E_DST: state_q <= ST_RESULT;
				ST_READ:  state_q <= ST_RESULT;
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_NODE) begin
						it_q   <= '0;
						ecnt_q <= '0;
						state_q <= (iter_cfg_q == '0) ? ST_RESULT : ST_A_EDGE;
					end
				end
				ST_A_EDGE: begin
					if (ecnt_q == edge_total_q) begin
						cnt_q   <= '0;
						state_q <= ST_B_READ;
					end else begin
						state_q <= ST_A_NODE;
					end
				end
				ST_A_NODE: state_q <= ST_A_DIV;
				ST_A_DIV:  state_q <= ST_A_WAIT;
				ST_A_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_A_ACC;
					end
				end
				ST_A_ACC: begin
					ecnt_q  <= ecnt_q + 1'b1;
					state_q <= ST_A_EDGE;
				end
				ST_B_READ: state_q <= ST_B_SCL;
				ST_B_SCL:  state_q <= ST_B_WAIT;
				ST_B_WAIT: begin
					if (scale_out_valid) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST_NODE) begin
							it_q   <= it_q + 1'b1;
							ecnt_q <= '0;
							state_q <= (8'(it_q + 1'b1) == iter_cfg_q) ? ST_RESULT
							                                           : ST_A_EDGE;
						end else begin
							state_q <= ST_B_READ;
						end
					end
				end
				ST_RESULT: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request fields, edge operands and the pending result.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			src_q         <= src_node;
			dst_q         <= dst_node;
			res_index_q   <= (kind == pie_pkg::KIND_EDGE || kind == pie_pkg::KIND_READ)
			                 ? src_node : '0;
			res_rank_q    <= '0;
			res_present_q <= 1'b0;
			res_status_q  <= (kind == pie_pkg::KIND_EDGE && edge_full) ? pie_pkg::STAT_DROPPED
			               : (kind == pie_pkg::KIND_COMPUTE) ? pie_pkg::STAT_DONE
			                                                 : pie_pkg::STAT_OK;
		end
		if (state_q == ST_E_SRC) begin
			deg_new_q <= node_rdata.degree + 1'b1;
		end
		if (state_q == ST_E_DST) begin
			res_present_q <= 1'b1;
		end
		if (state_q == ST_READ) begin
			res_present_q <= node_rdata.present;
			res_rank_q    <= node_rdata.present ? rank_rdata : '0;
		end
		if (state_q == ST_A_NODE) begin
			edst_q <= edge_rdata.dst;
		end
		if (state_q == ST_A_WAIT && div_rsp.done) begin
			quot_q <= div_rsp.quotient;
		end
	end

	// Result register toward the rsp channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && rsp_free) begin
			rsp_index_q   <= res_index_q;
			rsp_rank_q    <= res_rank_q;
			rsp_present_q <= res_present_q;
			rsp_status_q  <= res_status_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign node_index   = rsp_index_q;
	assign rank_value   = rsp_rank_q;
	assign node_present = rsp_present_q;
	assign status       = rsp_status_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cfg_q <= 8'd50;
			base_cfg_q <= CW'(9830);
			damp_cfg_q <= CW'(55706);
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				pie_pkg::REG_ITER:    iter_cfg_q <= pwdata[7:0];
				pie_pkg::REG_BASE:    base_cfg_q <= pwdata[CW-1:0];
				pie_pkg::REG_DAMPING: damp_cfg_q <= pwdata[CW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pie_pkg::REG_ITER:    prdata = 32'(iter_cfg_q);
			pie_pkg::REG_BASE:    prdata = 32'(base_cfg_q);
			pie_pkg::REG_DAMPING: prdata = 32'(damp_cfg_q);
			default:              prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	`PIE_ASSERT_IMPL(a_edge_bound, clk, arst_n, 1'b1, edge_total_q <= ECW'(pie_pkg::MAX_EDGES))
	`PIE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`PIE_ASSERT_IMPL(a_div_start_idle, clk, arst_n, div_start, !div_busy)
	`PIE_ASSERT_IMPL(a_scale_in_sweep, clk, arst_n, scale_out_valid, state_q == ST_B_WAIT)

endmodule
